>>> rtl/core/fpc_pkg.sv
// shared types and constants of the frame pacing controller
`default_nettype none

package fpc_pkg;

  // field widths
  localparam int TARGET_W = 10;
  localparam int FRAME_W  = 16;
  localparam int SLEEP_W  = 10;
  localparam int AVG_W    = 16;
  localparam int LAG_W    = 10;

  // window and queue sizing
  localparam int WINDOW_SIZE_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(16);

  // register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_TARGET  = 2'd0,
    REG_LIMITER = 2'd1,
    REG_SKIPPER = 2'd2
  } fpc_reg_idx_t;

  // configuration bundle handed to front and back
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic                limiter_en;
    logic                skipper_en;
  } fpc_cfg_t;

  // classified request: fast frame flag and distance to target
  typedef struct packed {
    logic               is_fast;
    logic [FRAME_W-1:0] diff;
  } fpc_cls_t;

endpackage

`default_nettype wire

>>> rtl/core/fpc_front.sv
// front part: window of recent durations, running sum and frame classification
`default_nettype none

module fpc_front import fpc_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  localparam int SUM_W = FRAME_W + $clog2(WINDOW_SIZE)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fpc_cfg_t           cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FRAME_W-1:0] in_frame_ms,
  input  logic               q_full,
  output logic               q_push,
  output fpc_cls_t           q_cls,
  output logic [SUM_W-1:0]   q_sum
);

  logic [FRAME_W-1:0] hist_r [WINDOW_SIZE];
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic [FRAME_W-1:0] target_ext;
  logic               accept;

  // request accepted whenever the queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // running sum: drop the oldest sample, add the new one
  assign sum_nxt = sum_r - SUM_W'(hist_r[WINDOW_SIZE-1]) + SUM_W'(in_frame_ms);
  assign q_sum   = sum_nxt;

  // classify against the target
  assign target_ext    = FRAME_W'(cfg.target);
  assign q_cls.is_fast = in_frame_ms < target_ext;
  assign q_cls.diff    = q_cls.is_fast ? (target_ext - in_frame_ms)
                                       : (in_frame_ms - target_ext);

  // shift line of recent durations, oldest at the far end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        hist_r[i] <= '0;
      end
      sum_r <= '0;
    end else if (accept) begin
      hist_r[0] <= in_frame_ms;
      for (int i = 1; i < WINDOW_SIZE; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fpc_queue.sv
// short fifo between the front and back parts
`default_nettype none

module fpc_queue import fpc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = data_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fpc_back.sv
// back part: frame limiter, frame-skip policy, window average and result register
`default_nettype none

module fpc_back import fpc_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  localparam int SUM_W = FRAME_W + $clog2(WINDOW_SIZE)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fpc_cfg_t           cfg,
  input  logic               q_empty,
  output logic               q_pop,
  input  fpc_cls_t           q_cls,
  input  logic [SUM_W-1:0]   q_sum,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLEEP_W-1:0] out_sleep_ms,
  output logic               out_skip_half,
  output logic               out_show_frame,
  output logic [AVG_W-1:0]   out_average_ms,
  output logic [LAG_W-1:0]   out_lag_budget
);

  // reciprocal of the window size, exact for every sum below 2**SUM_W
  localparam int LOG_W   = $clog2(WINDOW_SIZE);
  localparam int SHIFT   = SUM_W + LOG_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int GROW_W  = FRAME_W + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic               out_valid_r;
  logic [SLEEP_W-1:0] sleep_r;
  logic               skip_r;
  logic               show_r;
  logic [AVG_W-1:0]   avg_r;
  logic [LAG_W-1:0]   lag_r;
  logic [1:0]         phase_r;

  logic [LAG_W-1:0]   d_fast;
  logic               lag_covers;
  logic [GROW_W-1:0]  grown;
  logic               grown_sat;
  logic [LAG_W-1:0]   lag_nxt;
  logic [SLEEP_W-1:0] sleep_nxt;
  logic [LAG_W-1:0]   half_target;
  logic               skip_nxt;
  logic               show_nxt;
  logic [1:0]         phase_nxt;
  logic [1:0]         phase_inc;
  logic [PROD_W-1:0]  prod;

  // take the next request when the result register is free or draining
  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  // frame limiter
  assign d_fast     = q_cls.diff[LAG_W-1:0];
  assign lag_covers = lag_r >= d_fast;
  assign grown      = GROW_W'(lag_r) + GROW_W'(q_cls.diff);
  assign grown_sat  = grown >= GROW_W'(cfg.target);

  always_comb begin
    lag_nxt   = lag_r;
    sleep_nxt = '0;
    if (cfg.limiter_en) begin
      if (q_cls.is_fast) begin
        if (lag_covers) begin
          lag_nxt = lag_r - d_fast;
        end else begin
          sleep_nxt = d_fast - lag_r;
          lag_nxt   = '0;
        end
      end else begin
        lag_nxt = grown_sat ? cfg.target : grown[LAG_W-1:0];
      end
    end
  end

  // frame-skip policy on the updated budget
  assign half_target = cfg.target >> 1;
  assign phase_inc   = phase_r + 2'd1;

  always_comb begin
    skip_nxt  = skip_r;
    show_nxt  = show_r;
    phase_nxt = phase_r;
    if (cfg.skipper_en) begin
      if (lag_nxt == '0) begin
        skip_nxt = 1'b0;
      end else if (lag_nxt >= half_target) begin
        skip_nxt = 1'b1;
        if (lag_nxt >= cfg.target) begin
          phase_nxt = phase_inc;
          show_nxt  = phase_inc == 2'd0;
        end
      end
    end
  end

  // window average by reciprocal multiply
  assign prod = PROD_W'(q_sum) * PROD_W'(RECIP);

  // pacing state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      lag_r       <= '0;
      phase_r     <= '0;
      skip_r      <= 1'b0;
      show_r      <= 1'b0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
        lag_r       <= lag_nxt;
        phase_r     <= phase_nxt;
        skip_r      <= skip_nxt;
        show_r      <= show_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sleep_r <= sleep_nxt;
      avg_r   <= prod[SHIFT+AVG_W-1:SHIFT];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sleep_ms   = sleep_r;
  assign out_skip_half  = skip_r;
  assign out_show_frame = show_r;
  assign out_average_ms = avg_r;
  assign out_lag_budget = lag_r;

endmodule

`default_nettype wire

>>> rtl/core/frame_pacing_controller_core.sv
// top level of the frame pacing controller: register port, front, queue and back
//
//   channel   handshake                 payload
//   in        in_valid / in_ready       in_frame_ms
//   out       out_valid / out_ready     out_sleep_ms, out_skip_half, out_show_frame,
//                                       out_average_ms, out_lag_budget
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one request per cycle sustained while results are taken; a result passes through the queue
// register, then the result register, and the rate is set by the update of the budget
// and skip state in the back part
// reset is synchronous and active low; the window clears at once, no clearing pass
// when results are not taken the two-entry queue fills and in_ready drops
`default_nettype none

module frame_pacing_controller_core import fpc_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FRAME_W-1:0] in_frame_ms,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLEEP_W-1:0] out_sleep_ms,
  output logic               out_skip_half,
  output logic               out_show_frame,
  output logic [AVG_W-1:0]   out_average_ms,
  output logic [LAG_W-1:0]   out_lag_budget,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int SUM_W = FRAME_W + $clog2(WINDOW_SIZE);
  localparam int QW    = $bits(fpc_cls_t) + SUM_W;

  logic [TARGET_W-1:0] target_r;
  logic                limiter_en_r;
  logic                skipper_en_r;
  fpc_cfg_t            cfg;
  fpc_reg_idx_t        reg_idx;
  logic                wr_en;

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  fpc_cls_t            front_cls;
  logic [SUM_W-1:0]    front_sum;
  fpc_cls_t            back_cls;
  logic [SUM_W-1:0]    back_sum;
  logic [QW-1:0]       q_wdata;
  logic [QW-1:0]       q_rdata;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = fpc_reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= TARGET_RST;
      limiter_en_r <= 1'b1;
      skipper_en_r <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TARGET:  target_r     <= pwdata[TARGET_W-1:0];
        REG_LIMITER: limiter_en_r <= pwdata[0];
        REG_SKIPPER: skipper_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (reg_idx)
      REG_TARGET:  prdata = PDATA_W'(target_r);
      REG_LIMITER: prdata = PDATA_W'(limiter_en_r);
      REG_SKIPPER: prdata = PDATA_W'(skipper_en_r);
      default:     prdata = '0;
    endcase
  end

  assign cfg.target     = target_r;
  assign cfg.limiter_en = limiter_en_r;
  assign cfg.skipper_en = skipper_en_r;

  fpc_front #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_frame_ms(in_frame_ms),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cls      (front_cls),
    .q_sum      (front_sum)
  );

  assign q_wdata = {front_cls, front_sum};
  assign {back_cls, back_sum} = q_rdata;

  fpc_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .full     (q_full),
    .empty    (q_empty)
  );

  fpc_back #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_cls         (back_cls),
    .q_sum         (back_sum),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sleep_ms  (out_sleep_ms),
    .out_skip_half (out_skip_half),
    .out_show_frame(out_show_frame),
    .out_average_ms(out_average_ms),
    .out_lag_budget(out_lag_budget)
  );

endmodule

`default_nettype wire

>>> rtl/core/fpc_checker.sv
// port-level checks of the frame pacing controller and their binding
`default_nettype none

module fpc_checker import fpc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SLEEP_W-1:0] out_sleep_ms,
  input logic               out_skip_half,
  input logic               out_show_frame,
  input logic [AVG_W-1:0]   out_average_ms,
  input logic [LAG_W-1:0]   out_lag_budget,
  input logic               psel,
  input logic               penable,
  input logic               pready
);

  // a sleep is only asked for once the budget is used up
  a_sleep_empties_budget: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_sleep_ms != '0) |-> out_lag_budget == '0)
    else $error("sleep reported with a nonzero lag budget");

  // no stale result survives reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a result held back keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sleep_ms)
      && $stable(out_lag_budget) && $stable(out_average_ms)
      && $stable(out_skip_half) && $stable(out_show_frame))
    else $error("result changed while stalled");

  // register port never inserts wait states
  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable |-> pready)
    else $error("register access stalled");

endmodule

bind frame_pacing_controller_core fpc_checker u_fpc_checker (.*);

`default_nettype wire
